// ===== design/mvna_pkg.sv =====
// ============================================================================
// mvna_pkg: shared types and constants of the vertex normal accumulator
// Holds the table sizes, command codes and the controller/datapath bundles.
// ============================================================================
package mvna_pkg;

    localparam int ADDR_W  = 12;
    localparam int DEPTH   = 4096;
    localparam int COORD_W = 16;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int FACE_W  = PROD_W + 1;
    localparam int ACC_W   = 48;
    localparam int NORM_W  = 16;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Source of the accumulator memory address.
    typedef enum logic [1:0] {
        ASEL_CLR    = 2'd0,
        ASEL_VTX    = 2'd1,
        ASEL_CORNER = 2'd2
    } t_asel;

    typedef struct packed {
        logic              load;
        logic              vtx_wr;
        logic              lat_a;
        logic              lat_e1;
        logic              lat_e2;
        logic              mul_en;
        logic              acc_wr;
        logic              acc_clr;
        logic              mag_load;
        logic              shr;
        logic              shl;
        logic              sq_en;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              div_init;
        logic              div_step;
        logic              div_store;
        logic              out_load;
        logic [1:0]        sel;
        t_asel             asel;
        logic [4:0]        cnt;
        logic [ADDR_W-1:0] clr_addr;
    } t_dp_ctl;

    typedef struct packed {
        logic m_zero;
        logic m_hi;
        logic m_lo;
    } t_dp_stat;

endpackage

// ===== design/mvna_ctrl.sv =====
// ============================================================================
// mvna_ctrl: sequencer of the vertex normal accumulator
// Clears the accumulators after reset, then steps each command through the
// datapath and owns both stream handshakes.
// ============================================================================
module mvna_ctrl
    import mvna_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_cmd,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl
);

    typedef enum logic [18:0] {
        ST_CLEAR = 19'h00001,
        ST_IDLE  = 19'h00002,
        ST_VWR   = 19'h00004,
        ST_TRA   = 19'h00008,
        ST_TRB   = 19'h00010,
        ST_TRC   = 19'h00020,
        ST_TE2   = 19'h00040,
        ST_TMUL  = 19'h00080,
        ST_TARD  = 19'h00100,
        ST_TAWR  = 19'h00200,
        ST_RARD  = 19'h00400,
        ST_RMAG  = 19'h00800,
        ST_RNORM = 19'h01000,
        ST_RSQ   = 19'h02000,
        ST_RSQI  = 19'h04000,
        ST_RSQRT = 19'h08000,
        ST_RDIVI = 19'h10000,
        ST_RDIV  = 19'h20000,
        ST_ROUT  = 19'h40000
    } t_state;

    t_state            r_state, n_state;
    logic [4:0]        r_cnt, n_cnt;
    logic [1:0]        r_sel, n_sel;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_sel    <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sel    = r_sel;
        n_clr    = r_clr;
        n_ovalid = r_ovalid & ~i_out_ready;
        o_ctl          = '0;
        o_ctl.sel      = r_sel;
        o_ctl.cnt      = r_cnt;
        o_ctl.clr_addr = r_clr;
        o_ctl.asel     = ASEL_CORNER;
        unique case (r_state)
            ST_CLEAR: begin
                o_ctl.asel    = ASEL_CLR;
                o_ctl.acc_wr  = 1'b1;
                o_ctl.acc_clr = 1'b1;
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_sel = 2'd0;
                    n_cnt = 5'd0;
                    unique case (i_cmd)
                        CMD_STORE: n_state = ST_VWR;
                        CMD_TRI:   n_state = ST_TRA;
                        CMD_READ:  n_state = ST_RARD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_VWR: begin
                o_ctl.vtx_wr = 1'b1;
                n_state = ST_IDLE;
            end
            ST_TRA: begin
                n_sel   = 2'd1;
                n_state = ST_TRB;
            end
            ST_TRB: begin
                o_ctl.lat_a = 1'b1;
                n_sel   = 2'd2;
                n_state = ST_TRC;
            end
            ST_TRC: begin
                o_ctl.lat_e1 = 1'b1;
                n_state = ST_TE2;
            end
            ST_TE2: begin
                o_ctl.lat_e2 = 1'b1;
                n_cnt   = 5'd0;
                n_state = ST_TMUL;
            end
            ST_TMUL: begin
                o_ctl.mul_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd6) begin
                    n_sel   = 2'd0;
                    n_state = ST_TARD;
                end
            end
            ST_TARD: begin
                n_state = ST_TAWR;
            end
            ST_TAWR: begin
                o_ctl.acc_wr = 1'b1;
                if (r_sel == 2'd2) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sel   = r_sel + 1'b1;
                    n_state = ST_TARD;
                end
            end
            ST_RARD: begin
                o_ctl.asel = ASEL_VTX;
                n_state = ST_RMAG;
            end
            ST_RMAG: begin
                o_ctl.mag_load = 1'b1;
                n_state = ST_RNORM;
            end
            ST_RNORM: begin
                if (i_stat.m_zero) begin
                    n_state = ST_ROUT;
                end else if (i_stat.m_hi) begin
                    o_ctl.shr = 1'b1;
                end else if (i_stat.m_lo) begin
                    o_ctl.shl = 1'b1;
                end else begin
                    n_cnt   = 5'd0;
                    n_state = ST_RSQ;
                end
            end
            ST_RSQ: begin
                o_ctl.sq_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd3) begin
                    n_state = ST_RSQI;
                end
            end
            ST_RSQI: begin
                o_ctl.sqrt_init = 1'b1;
                n_cnt   = 5'd0;
                n_state = ST_RSQRT;
            end
            ST_RSQRT: begin
                o_ctl.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_sel   = 2'd0;
                    n_state = ST_RDIVI;
                end
            end
            ST_RDIVI: begin
                o_ctl.div_init = 1'b1;
                n_cnt   = 5'd0;
                n_state = ST_RDIV;
            end
            ST_RDIV: begin
                if (r_cnt == 5'd15) begin
                    o_ctl.div_store = 1'b1;
                    if (r_sel == 2'd2) begin
                        n_state = ST_ROUT;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = ST_RDIVI;
                    end
                end else begin
                    o_ctl.div_step = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ROUT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mvna_dp.sv =====
// ============================================================================
// mvna_dp: datapath of the vertex normal accumulator
// Vertex and accumulator memories, the shared multiplier, the normalizing
// shifter and the bit-serial square root and divider.
// ============================================================================
module mvna_dp
    import mvna_pkg::*;
(
    input  logic         i_clk,
    input  t_dp_ctl      i_ctl,
    input  logic [95:0]  i_data,
    output t_dp_stat     o_stat,
    output logic [63:0]  o_tdata,
    output logic [0:0]   o_tuser
);

    localparam int AROW_W = 3 * ACC_W + 1;

    function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [FACE_W-1:0] f);
        logic [ACC_W:0] sum;
        logic [ACC_W:0] res;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-FACE_W){f[FACE_W-1]}}, f};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            res = sum[ACC_W] ? {1'b1, 1'b1, {(ACC_W-1){1'b0}}}
                             : {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            res = {1'b0, sum[ACC_W-1:0]};
        end
        return res;
    endfunction

    // Captured command payload.
    logic [ADDR_W-1:0]  r_vi;
    logic [COORD_W-1:0] r_pos [3];
    logic [ADDR_W-1:0]  r_corner [3];

    logic [3*COORD_W-1:0] mem_vtx [DEPTH];
    logic [3*COORD_W-1:0] r_vrd;
    logic [AROW_W-1:0]    mem_acc [DEPTH];
    logic [AROW_W-1:0]    r_ard;

    logic signed [EDGE_W-1:0] r_a  [3];
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [PROD_W-1:0] r_prod;
    logic signed [FACE_W-1:0] r_f [3];

    logic [ACC_W-1:0]  r_mag [3];
    logic [2:0]        r_sign;
    logic              r_sat;
    logic [59:0]       r_sq;
    logic [61:0]       r_s;
    logic [62:0]       r_v, r_res, r_bit;
    logic [30:0]       r_rem;
    logic [14:0]       r_nlo;
    logic [14:0]       r_q;
    logic [NORM_W-1:0] r_w [3];

    logic [ADDR_W-1:0]        corner_sel, acc_addr;
    logic signed [EDGE_W-1:0] vrd [3];
    logic signed [EDGE_W-1:0] opa, opb;
    logic [2:0]               cm1;
    logic [AROW_W-1:0]        acc_wdata;
    logic [ACC_W:0]           sx, sy, sz;
    logic [ACC_W-1:0]         m01, m_max;
    logic [63:0]              rt_sum;
    logic [30:0]              root;
    logic [44:0]              num;
    logic [31:0]              dtry;

    always_comb begin
        case (i_ctl.sel)
            2'd1:    corner_sel = r_corner[1];
            2'd2:    corner_sel = r_corner[2];
            default: corner_sel = r_corner[0];
        endcase
        unique case (i_ctl.asel)
            ASEL_CLR: acc_addr = i_ctl.clr_addr;
            ASEL_VTX: acc_addr = r_vi;
            default:  acc_addr = corner_sel;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_vi        <= i_data[11:0];
            r_pos[0]    <= i_data[27:12];
            r_pos[1]    <= i_data[43:28];
            r_pos[2]    <= i_data[59:44];
            r_corner[0] <= i_data[71:60];
            r_corner[1] <= i_data[83:72];
            r_corner[2] <= i_data[95:84];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vtx_wr) begin
            mem_vtx[r_vi] <= {r_pos[2], r_pos[1], r_pos[0]};
        end
        r_vrd <= mem_vtx[corner_sel];
    end

    // Face normal adds, or zero rows during the clearing pass.
    always_comb begin
        sx = sat_add(r_ard[ACC_W-1:0], r_f[0]);
        sy = sat_add(r_ard[2*ACC_W-1:ACC_W], r_f[1]);
        sz = sat_add(r_ard[3*ACC_W-1:2*ACC_W], r_f[2]);
        if (i_ctl.acc_clr) begin
            acc_wdata = '0;
        end else begin
            acc_wdata = {r_ard[AROW_W-1] | sx[ACC_W] | sy[ACC_W] | sz[ACC_W],
                         sz[ACC_W-1:0], sy[ACC_W-1:0], sx[ACC_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_wr) begin
            mem_acc[acc_addr] <= acc_wdata;
        end
        r_ard <= mem_acc[acc_addr];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vrd[k] = {r_vrd[k*COORD_W+COORD_W-1], r_vrd[k*COORD_W +: COORD_W]};
        end
        case (i_ctl.cnt[2:0])
            3'd0:    begin opa = r_e1[1]; opb = r_e2[2]; end
            3'd1:    begin opa = r_e1[2]; opb = r_e2[1]; end
            3'd2:    begin opa = r_e1[2]; opb = r_e2[0]; end
            3'd3:    begin opa = r_e1[0]; opb = r_e2[2]; end
            3'd4:    begin opa = r_e1[0]; opb = r_e2[1]; end
            3'd5:    begin opa = r_e1[1]; opb = r_e2[0]; end
            default: begin opa = '0;      opb = '0;      end
        endcase
        cm1 = i_ctl.cnt[2:0] - 3'd1;
    end

    // Cross product: one product a cycle, folded into the face normal.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_ctl.lat_a) begin
                r_a[k] <= vrd[k];
            end
            if (i_ctl.lat_e1) begin
                r_e1[k] <= vrd[k] - r_a[k];
            end
            if (i_ctl.lat_e2) begin
                r_e2[k] <= vrd[k] - r_a[k];
            end
        end
        if (i_ctl.mul_en) begin
            r_prod <= opa * opb;
            if (i_ctl.cnt[2:0] != 3'd0) begin
                if (!cm1[0]) begin
                    r_f[cm1[2:1]] <= FACE_W'(r_prod);
                end else begin
                    r_f[cm1[2:1]] <= r_f[cm1[2:1]] - FACE_W'(r_prod);
                end
            end
        end
    end

    always_comb begin
        m01    = (r_mag[1] > r_mag[0]) ? r_mag[1] : r_mag[0];
        m_max  = (r_mag[2] > m01) ? r_mag[2] : m01;
        o_stat.m_zero = (m_max == '0);
        o_stat.m_hi   = (m_max[ACC_W-1:30] != '0);
        o_stat.m_lo   = (m_max[ACC_W-1:29] == '0);
        rt_sum = {1'b0, r_res} + {1'b0, r_bit};
        root   = r_res[30:0];
        num    = {1'b0, r_mag[i_ctl.sel][29:0], 14'd0} + 45'(r_res[30:1]);
        dtry   = {r_rem, r_nlo[14]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mag_load) begin
            r_sat <= r_ard[AROW_W-1];
            for (int k = 0; k < 3; k++) begin
                r_sign[k] <= r_ard[k*ACC_W+ACC_W-1];
                r_mag[k]  <= r_ard[k*ACC_W+ACC_W-1] ? -r_ard[k*ACC_W +: ACC_W]
                                                    : r_ard[k*ACC_W +: ACC_W];
                r_w[k]    <= '0;
            end
        end else if (i_ctl.shr) begin
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= r_mag[k] >> 1;
            end
        end else if (i_ctl.shl) begin
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= r_mag[k] << 1;
            end
        end
        if (i_ctl.sq_en) begin
            if (i_ctl.cnt[1:0] != 2'd3) begin
                r_sq <= r_mag[i_ctl.cnt[1:0]][29:0] * r_mag[i_ctl.cnt[1:0]][29:0];
            end
            if (i_ctl.cnt[1:0] == 2'd1) begin
                r_s <= 62'(r_sq);
            end else if (i_ctl.cnt[1:0] != 2'd0) begin
                r_s <= r_s + 62'(r_sq);
            end
        end
        // Square root, two bits of the radicand a step.
        if (i_ctl.sqrt_init) begin
            r_v   <= 63'(r_s);
            r_res <= '0;
            r_bit <= {1'b1, 62'd0};
        end else if (i_ctl.sqrt_step) begin
            if ({1'b0, r_v} >= rt_sum) begin
                r_v   <= r_v - rt_sum[62:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        // Restoring division, one quotient bit a step.
        if (i_ctl.div_init) begin
            r_rem <= 31'(num[44:15]);
            r_nlo <= num[14:0];
            r_q   <= '0;
        end else if (i_ctl.div_step) begin
            if (dtry >= {1'b0, root}) begin
                r_rem <= 31'(dtry - {1'b0, root});
                r_q   <= {r_q[13:0], 1'b1};
            end else begin
                r_rem <= dtry[30:0];
                r_q   <= {r_q[13:0], 1'b0};
            end
            r_nlo <= r_nlo << 1;
        end
        if (i_ctl.div_store) begin
            r_w[i_ctl.sel] <= r_sign[i_ctl.sel] ? -{1'b0, r_q} : {1'b0, r_q};
        end
        if (i_ctl.out_load) begin
            o_tdata <= {4'd0, r_w[2], r_w[1], r_w[0], r_vi};
            o_tuser <= r_sat;
        end
    end

endmodule

// ===== design/mesh_vertex_normal_accumulator.sv =====
// ============================================================================
// mesh_vertex_normal_accumulator: area-weighted per-vertex mesh normals
// Stores vertices, accumulates triangle face normals per corner and returns
// unit normals in signed Q1.14.
// ============================================================================
// Usage. Each input transaction carries a command in s_axis_tuser. A store
// writes one vertex position, a triangle adds its face normal (B-A)x(C-A)
// with saturation into the accumulators of its three corners, and a read
// returns one output transaction with the vertex's normal scaled to unit
// length; a zero accumulator reads back as a zero vector. Stores and
// triangles give no output transaction, and command 3 is dropped.
// The block works on one command at a time. The time a triangle takes is
// set by the three vertex reads, the single shared multiplier for the six
// cross-product terms and the three read-modify-write passes over one
// accumulator memory port. A read makes up to 29 one-bit normalizing shifts,
// squares the three magnitudes and sums them, runs 32 square-root steps and
// then divides each of the three components in turn. A zero accumulator
// skips the arithmetic. m_axis_tvalid rises in the cycle in which
// s_axis_tready comes back. After reset the block clears all 4096 accumulator
// rows, one per cycle, so s_axis_tready stays low until the clearing pass is
// done. The finished result sits in an output register; the block keeps taking
// commands while it waits, and a second read stalls at its final step until
// m_axis_tready frees the register.
module mesh_vertex_normal_accumulator
    import mvna_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [95:0] s_axis_tdata,
    // cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_index, norm_x, norm_y, norm_z, zero padding
    output logic [63:0] m_axis_tdata,
    // saturated
    output logic [0:0]  m_axis_tuser
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    // The controller sequences every command; the datapath only obeys.
    mvna_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_cmd       (t_cmd'(s_axis_tuser)),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    mvna_dp u_dp (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_data  (s_axis_tdata),
        .o_stat  (stat),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser)
    );

endmodule

// ===== bench/mvna_normal_checker.sv =====
// ============================================================================
// mvna_normal_checker: predictor and scoreboard of the normal accumulator
// Watches both stream channels. It keeps its own vertex table and
// accumulators, predicts each read result, and compares it field by field.
// ============================================================================
module mvna_normal_checker
    import mvna_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 47);

    typedef struct {
        logic [ADDR_W-1:0] idx;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
        logic              sat;
    } t_normal;

    int      pos_x [DEPTH];
    int      pos_y [DEPTH];
    int      pos_z [DEPTH];
    longint  sum_x [DEPTH];
    longint  sum_y [DEPTH];
    longint  sum_z [DEPTH];
    bit      clipped [DEPTH];
    t_normal normals_due[$];
    int      fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = normals_due.size();

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
            sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
            clipped[i] = 0;
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    function automatic longint clamp_add(longint acc, longint add, ref bit flag);
        longint s;
        s = acc + add;
        if (s > ACC_HI) begin
            s = ACC_HI;
            flag = 1;
        end
        if (s < ACC_LO) begin
            s = ACC_LO;
            flag = 1;
        end
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Adds the face normal (B-A)x(C-A) into the sums of all three corners.
    task automatic add_face(int a, int b, int c);
        longint e1x, e1y, e1z, e2x, e2y, e2z, fx, fy, fz;
        int corner[3];
        e1x = pos_x[b] - pos_x[a]; e1y = pos_y[b] - pos_y[a]; e1z = pos_z[b] - pos_z[a];
        e2x = pos_x[c] - pos_x[a]; e2y = pos_y[c] - pos_y[a]; e2z = pos_z[c] - pos_z[a];
        fx = e1y * e2z - e1z * e2y;
        fy = e1z * e2x - e1x * e2z;
        fz = e1x * e2y - e1y * e2x;
        corner[0] = a; corner[1] = b; corner[2] = c;
        for (int k = 0; k < 3; k++) begin
            sum_x[corner[k]] = clamp_add(sum_x[corner[k]], fx, clipped[corner[k]]);
            sum_y[corner[k]] = clamp_add(sum_y[corner[k]], fy, clipped[corner[k]]);
            sum_z[corner[k]] = clamp_add(sum_z[corner[k]], fz, clipped[corner[k]]);
        end
    endtask

    function automatic logic [NORM_W-1:0] unit_part(longint unsigned mag, longint unsigned len,
                                                    longint acc);
        longint unsigned q;
        q = (mag * 16384 + len / 2) / len;
        return acc < 0 ? NORM_W'(-q) : NORM_W'(q);
    endfunction

    function automatic t_normal unit_normal(int i);
        t_normal         r;
        longint unsigned mx, my, mz, m, len;
        r.idx = ADDR_W'(i);
        r.sat = clipped[i];
        r.nx = '0; r.ny = '0; r.nz = '0;
        mx = sum_x[i] < 0 ? -sum_x[i] : sum_x[i];
        my = sum_y[i] < 0 ? -sum_y[i] : sum_y[i];
        mz = sum_z[i] < 0 ? -sum_z[i] : sum_z[i];
        m = mx;
        if (my > m) m = my;
        if (mz > m) m = mz;
        if (m == 0) return r;
        while (m >= (64'd1 << 30)) begin
            mx >>= 1; my >>= 1; mz >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            mx <<= 1; my <<= 1; mz <<= 1; m <<= 1;
        end
        len = int_sqrt(mx * mx + my * my + mz * mz);
        r.nx = unit_part(mx, len, sum_x[i]);
        r.ny = unit_part(my, len, sum_y[i]);
        r.nz = unit_part(mz, len, sum_z[i]);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (normals_due.size() == 0) begin
                    report_mismatch("pending read count", 0, 1);
                end else begin
                    want = normals_due.pop_front();
                    if (m_axis_tdata[11:0] !== want.idx)
                        report_mismatch("out_index", m_axis_tdata[11:0], want.idx);
                    if (m_axis_tdata[27:12] !== want.nx)
                        report_mismatch("norm_x", $signed(m_axis_tdata[27:12]), $signed(want.nx));
                    if (m_axis_tdata[43:28] !== want.ny)
                        report_mismatch("norm_y", $signed(m_axis_tdata[43:28]), $signed(want.ny));
                    if (m_axis_tdata[59:44] !== want.nz)
                        report_mismatch("norm_z", $signed(m_axis_tdata[59:44]), $signed(want.nz));
                    if (m_axis_tuser[0] !== want.sat)
                        report_mismatch("saturated", m_axis_tuser[0], want.sat);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (t_cmd'(s_axis_tuser))
                    CMD_STORE: begin
                        pos_x[s_axis_tdata[11:0]] = $signed(s_axis_tdata[27:12]);
                        pos_y[s_axis_tdata[11:0]] = $signed(s_axis_tdata[43:28]);
                        pos_z[s_axis_tdata[11:0]] = $signed(s_axis_tdata[59:44]);
                    end
                    CMD_TRI:  add_face(s_axis_tdata[71:60], s_axis_tdata[83:72],
                                       s_axis_tdata[95:84]);
                    CMD_READ: normals_due.push_back(unit_normal(s_axis_tdata[11:0]));
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== bench/mesh_vertex_normal_accumulator_test.sv =====
// ============================================================================
// mesh_vertex_normal_accumulator_test: stimulus and verdict for the block
// Drives stores, triangles, reads and unused commands, with directed extremes
// first and random mesh traffic after, under varying backpressure.
// ============================================================================
module mesh_vertex_normal_accumulator_test;
    import mvna_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    logic [95:0] s_axis_tdata = '0;
    // cmd
    logic [1:0]  s_axis_tuser = CMD_NOP;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    // out_index, norm_x, norm_y, norm_z, zero padding
    logic [63:0] m_axis_tdata;
    // saturated
    logic [0:0]  m_axis_tuser;

    int fail_count;
    int pending;

    // Idle percentages of each side; the stimulus moves them between phases.
    int tx_idle_pct = 22;
    int rx_idle_pct = 82;
    // A long receiver hold-off is requested by bumping hold_req.
    int hold_req = 0;
    int hold_done = 0;

    bit                written[DEPTH];
    logic [ADDR_W-1:0] stored_list[$];
    logic [ADDR_W-1:0] index_pool[$];

    mesh_vertex_normal_accumulator dut (.*);

    mvna_normal_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The run limit covers the accumulator clearing pass after reset, every
    // read at its slowest and both sides idling at their heaviest.
    initial begin
        #6.4ms;
        $display("mesh_vertex_normal_accumulator test failed");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off when requested, so that
    // the output register stays full and the block stops taking commands.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                m_axis_tready <= 0;
                repeat (2000) @(posedge i_clk);
                hold_done = hold_req;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // One input transaction: an optional idle gap, then hold it until taken.
    task automatic send(t_cmd c, logic [95:0] d);
        int gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        if (c == CMD_STORE && !written[d[11:0]]) begin
            written[d[11:0]] = 1;
            stored_list.push_back(d[11:0]);
        end
    endtask

    function automatic logic [95:0] word_of(logic [11:0] v, logic [15:0] x, logic [15:0] y,
                                            logic [15:0] z, logic [11:0] a, logic [11:0] b,
                                            logic [11:0] c);
        return {c, b, a, z, y, x, v};
    endfunction

    function automatic logic [11:0] any_stored();
        return stored_list[$urandom_range(0, stored_list.size() - 1)];
    endfunction

    initial begin
        logic [95:0] noise;
        logic [11:0] a, b, c;
        int          pick;
        int          n;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed part: coordinate extremes, both ends of the index range,
        // a degenerate triangle with a repeated corner, a read of a vertex
        // that no triangle touched, and the unused command.
        send(CMD_STORE, word_of(12'd0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
        send(CMD_STORE, word_of(12'd4095, 16'h7fff, 16'h7fff, 16'h8000, 0, 0, 0));
        send(CMD_STORE, word_of(12'd1, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0));
        send(CMD_STORE, word_of(12'd2, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
        send(CMD_TRI, word_of(0, 0, 0, 0, 12'd0, 12'd4095, 12'd1));
        send(CMD_TRI, word_of(0, 0, 0, 0, 12'd0, 12'd0, 12'd1));
        send(CMD_TRI, word_of(0, 0, 0, 0, 12'd2, 12'd1, 12'd4095));
        send(CMD_READ, word_of(12'd0, 0, 0, 0, 0, 0, 0));
        send(CMD_READ, word_of(12'd4095, 0, 0, 0, 0, 0, 0));
        send(CMD_READ, word_of(12'd1, 0, 0, 0, 0, 0, 0));
        send(CMD_READ, word_of(12'd2, 0, 0, 0, 0, 0, 0));
        send(CMD_READ, word_of(12'd3, 0, 0, 0, 0, 0, 0));
        send(CMD_NOP, {$urandom(), $urandom(), $urandom()});
        send(CMD_TRI, word_of(0, 0, 0, 0, 12'd4095, 12'd4095, 12'd4095));
        send(CMD_READ, word_of(12'd4095, 0, 0, 0, 0, 0, 0));

        // Random part: a small pool of vertices forms the mesh, so that
        // triangles pile up on shared corners and reads return real normals.
        index_pool = '{12'd0, 12'd1, 12'd2, 12'd4095};
        for (int i = 0; i < 40; i++) index_pool.push_back($urandom_range(0, DEPTH - 1));

        for (n = 0; n < 1035; n++) begin
            if (n == 340) begin
                tx_idle_pct = 82;
                rx_idle_pct = 22;
            end
            if (n == 690) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Let the block drain completely before going on.
            if (n == 500) begin
                s_axis_tvalid <= 0;
                do @(posedge i_clk); while (pending != 0);
            end
            // Long receiver hold-off while a burst of reads keeps coming.
            if (n == 800) hold_req++;

            noise = {$urandom(), $urandom(), $urandom()};
            pick = $urandom_range(0, 99);
            if (n >= 800 && n < 810) pick = 70;
            if (stored_list.size() < 4 || pick < 30) begin
                a = index_pool[$urandom_range(0, index_pool.size() - 1)];
                if ($urandom_range(0, 9) == 0) begin
                    noise[27:12] = $urandom_range(0, 15);
                    noise[43:28] = $urandom_range(0, 15);
                    noise[59:44] = $urandom_range(0, 15);
                end
                noise[11:0] = a;
                send(CMD_STORE, noise);
            end else if (pick < 65) begin
                a = any_stored();
                b = any_stored();
                c = ($urandom_range(0, 19) == 0) ? a : any_stored();
                noise[95:60] = {c, b, a};
                send(CMD_TRI, noise);
            end else if (pick < 95) begin
                noise[11:0] = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, DEPTH - 1))
                                                          : any_stored();
                send(CMD_READ, noise);
            end else begin
                send(CMD_NOP, noise);
            end
        end
        s_axis_tvalid <= 0;

        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("mesh_vertex_normal_accumulator test passed");
        end else begin
            $display("mesh_vertex_normal_accumulator test failed");
        end
        $finish;
    end

endmodule
